### design/spt_pkg.sv
// shared types and opcodes for the session pointer table
package spt_pkg;

    // operation codes carried with each request word
    typedef enum logic [1:0] {
        OP_ACK_UPDATE = 2'd0,
        OP_ACK_INIT   = 2'd1,
        OP_APP_WRITE  = 2'd2,
        OP_READ       = 2'd3
    } t_opcode;

    localparam int unsigned SID_BITS   = 10;
    localparam int unsigned FIELD_BITS = 16;

    typedef struct packed {
        t_opcode               opcode;
        logic [SID_BITS-1:0]   session_id;
        logic [FIELD_BITS-1:0] pointer_value;
        logic [FIELD_BITS-1:0] window_value;
    } t_req;

    typedef struct packed {
        logic [SID_BITS-1:0]   reply_session;
        logic [FIELD_BITS-1:0] acked_pointer;
        logic [FIELD_BITS-1:0] app_pointer;
        logic [FIELD_BITS-1:0] min_window_out;
    } t_reply;

    // per-store write enables toward the storage block
    typedef struct packed {
        logic acked;
        logic app;
        logic window;
    } t_wr_en;

endpackage

### design/spt_store.sv
// session entry storage: acked, app and optional window memories
module spt_store #(
    parameter int unsigned DEPTH   = 1024,
    parameter int unsigned AW      = 10,
    parameter int unsigned PW      = 16,
    parameter bit          NODELAY = 1'b0
) (
    input  logic                        i_clk,
    input  spt_pkg::t_wr_en             i_wr,
    input  logic                        i_rd,
    input  logic [AW-1:0]               i_addr,
    input  logic [PW-1:0]               i_acked_wdata,
    input  logic [PW-1:0]               i_app_wdata,
    input  logic [spt_pkg::FIELD_BITS-1:0] i_win_wdata,
    output logic [PW-1:0]               o_acked,
    output logic [PW-1:0]               o_app,
    output logic [spt_pkg::FIELD_BITS-1:0] o_win
);
    import spt_pkg::*;

    logic [PW-1:0] r_acked_mem [DEPTH];
    logic [PW-1:0] r_app_mem   [DEPTH];
    logic [PW-1:0] r_acked_q;
    logic [PW-1:0] r_app_q;

    always_ff @(posedge i_clk) begin
        if (i_wr.acked) begin
            r_acked_mem[i_addr] <= i_acked_wdata;
        end
        if (i_rd) begin
            r_acked_q <= r_acked_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.app) begin
            r_app_mem[i_addr] <= i_app_wdata;
        end
        if (i_rd) begin
            r_app_q <= r_app_mem[i_addr];
        end
    end

    assign o_acked = r_acked_q;
    assign o_app   = r_app_q;

    generate
        if (NODELAY) begin : g_win
            logic [FIELD_BITS-1:0] r_win_mem [DEPTH];
            logic [FIELD_BITS-1:0] r_win_q;

            always_ff @(posedge i_clk) begin
                if (i_wr.window) begin
                    r_win_mem[i_addr] <= i_win_wdata;
                end
                if (i_rd) begin
                    r_win_q <= r_win_mem[i_addr];
                end
            end

            assign o_win = r_win_q;
        end else begin : g_no_win
            // window not kept in this build
            assign o_win = '0;
        end
    endgenerate

endmodule

### design/session_pointer_table.sv
// session pointer table top level: request decode, storage and reply
//
// usage
//  - request channel: drive i_req and raise i_start; the word is taken at a
//    rising edge with i_start high and o_busy low. o_busy stays low, so one
//    request word can be taken every cycle
//  - opcodes: ack update writes the acked pointer (and window in no-delay
//    builds), ack init writes acked = value - 1 and app = value (and window
//    likewise), app write writes the app pointer, read returns one reply word
//  - reply channel: o_valid is high for exactly one cycle with o_reply; the
//    receiver cannot hold it off and must take it in that cycle
//  - read timing: a read reply shows in the cycle after the request is taken,
//    set by the registered memory read port; writes finish at the taking edge
//  - throughput: one request per cycle, set by the single shared address port
//    of the storage; a read right after a write to the same entry sees the
//    new value, since the write lands before the next read edge
//  - out-of-range sessions: writes are dropped, reads reply with zero data
//  - reset: clears only the reply strobe; memory contents are undefined until
//    each entry's ack init has been written
module session_pointer_table #(
    parameter int unsigned SESSION_COUNT = 1024,
    parameter int unsigned POINTER_BITS  = 16,
    parameter bit          NODELAY_MODE  = 1'b0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  spt_pkg::t_req   i_req,
    output logic            o_busy,
    output logic            o_valid,
    output spt_pkg::t_reply o_reply
);
    import spt_pkg::*;

    // address width follows the table depth
    localparam int unsigned AW = (SESSION_COUNT > 1) ? $clog2(SESSION_COUNT) : 1;
    localparam logic [16:0] SC = 17'(SESSION_COUNT);

    logic                  accept;
    logic                  in_range;
    logic [AW-1:0]         addr;
    logic [POINTER_BITS-1:0] ptr;
    logic [POINTER_BITS-1:0] ptr_minus_one;
    t_wr_en                wr;
    logic                  rd;

    logic [POINTER_BITS-1:0] acked_q;
    logic [POINTER_BITS-1:0] app_q;
    logic [FIELD_BITS-1:0]   win_q;

    logic                  r_valid;
    logic                  n_valid;
    logic                  r_in_range;
    logic [SID_BITS-1:0]   r_sid;

    // the table takes a word every cycle
    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;

    // entries beyond the table are not addressable
    assign in_range = (17'(i_req.session_id) < SC);
    assign addr     = AW'(i_req.session_id);

    // pointers are kept modulo 2^POINTER_BITS
    assign ptr           = POINTER_BITS'(i_req.pointer_value);
    assign ptr_minus_one = ptr - POINTER_BITS'(1);

    // opcode decode into per-store write enables
    always_comb begin
        wr = '0;
        rd = 1'b0;
        if (accept) begin
            case (i_req.opcode)
                OP_ACK_UPDATE: begin
                    wr.acked  = in_range;
                    wr.window = in_range;
                end
                OP_ACK_INIT: begin
                    wr.acked  = in_range;
                    wr.app    = in_range;
                    wr.window = in_range;
                end
                OP_APP_WRITE: begin
                    wr.app = in_range;
                end
                OP_READ: begin
                    rd = in_range;
                end
                default: begin
                    wr = '0;
                end
            endcase
        end
    end

    spt_store #(
        .DEPTH   (SESSION_COUNT),
        .AW      (AW),
        .PW      (POINTER_BITS),
        .NODELAY (NODELAY_MODE)
    ) u_store (
        .i_clk         (i_clk),
        .i_wr          (wr),
        .i_rd          (rd),
        .i_addr        (addr),
        // ack init stores value - 1, ack update stores value as is
        .i_acked_wdata ((i_req.opcode == OP_ACK_INIT) ? ptr_minus_one : ptr),
        .i_app_wdata   (ptr),
        .i_win_wdata   (i_req.window_value),
        .o_acked       (acked_q),
        .o_app         (app_q),
        .o_win         (win_q)
    );

    // reply strobe goes out the cycle after a read is taken
    assign n_valid = accept && (i_req.opcode == OP_READ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // reply side info, no reset needed
    always_ff @(posedge i_clk) begin
        if (n_valid) begin
            r_sid      <= i_req.session_id;
            r_in_range <= in_range;
        end
    end

    assign o_valid = r_valid;

    // out-of-range reads return zero data
    always_comb begin
        o_reply.reply_session  = r_sid;
        o_reply.acked_pointer  = r_in_range ? FIELD_BITS'(acked_q) : '0;
        o_reply.app_pointer    = r_in_range ? FIELD_BITS'(app_q) : '0;
        o_reply.min_window_out = r_in_range ? win_q : '0;
    end

endmodule

### dv/spt_reply_checker.sv
// reply checker: mirrors the pointer table, predicts read replies and compares them
`timescale 1ns / 100ps
module spt_reply_checker #(
    parameter int unsigned SESSION_COUNT = 1024,
    parameter int unsigned POINTER_BITS  = 16,
    parameter bit          NODELAY_MODE  = 1'b0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  spt_pkg::t_req   i_req,
    input  logic            i_busy,
    input  logic            i_valid,
    input  spt_pkg::t_reply i_reply,
    output int              o_mismatches,
    output int              o_waiting,
    output int              o_checked
);
    import spt_pkg::*;

    localparam longint unsigned PTR_MASK = (64'd1 << POINTER_BITS) - 64'd1;

    logic [31:0] acked_mirror  [SESSION_COUNT];
    logic [31:0] app_mirror    [SESSION_COUNT];
    logic [31:0] window_mirror [SESSION_COUNT];

    t_reply pending_replies[$];
    t_reply want;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("[%0t] %s: got 0x%0h, wanted 0x%0h", $realtime, what, got, exp_val);
        o_mismatches++;
    endtask

    // reply that a read of this word should produce
    function automatic t_reply predict_read(input t_req w);
        t_reply r;
        r = '0;
        r.reply_session = w.session_id;
        if (w.session_id < SESSION_COUNT) begin
            r.acked_pointer = acked_mirror[w.session_id][FIELD_BITS-1:0];
            r.app_pointer   = app_mirror[w.session_id][FIELD_BITS-1:0];
            if (NODELAY_MODE)
                r.min_window_out = window_mirror[w.session_id][FIELD_BITS-1:0];
        end
        return r;
    endfunction

    task automatic update_mirror(input t_req w);
        logic [31:0] ptr;
        ptr = 32'(w.pointer_value) & 32'(PTR_MASK);
        if (w.session_id < SESSION_COUNT) begin
            case (w.opcode)
                OP_ACK_UPDATE: begin
                    acked_mirror[w.session_id] = ptr;
                    if (NODELAY_MODE)
                        window_mirror[w.session_id] = 32'(w.window_value);
                end
                OP_ACK_INIT: begin
                    // acked trails the app pointer by one, wrapping at the pointer width
                    acked_mirror[w.session_id] = (ptr - 32'd1) & 32'(PTR_MASK);
                    app_mirror[w.session_id]   = ptr;
                    if (NODELAY_MODE)
                        window_mirror[w.session_id] = 32'(w.window_value);
                end
                OP_APP_WRITE: app_mirror[w.session_id] = ptr;
                default: ;
            endcase
        end
    endtask

    // reply is retired before the request of the same edge is applied
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid) begin
                if (pending_replies.size() == 0) begin
                    report_mismatch("reply word with no read outstanding",
                                    32'(i_reply.reply_session), 32'd0);
                end else begin
                    want = pending_replies.pop_front();
                    if (i_reply.reply_session !== want.reply_session)
                        report_mismatch("reply_session", 32'(i_reply.reply_session),
                                        32'(want.reply_session));
                    if (i_reply.acked_pointer !== want.acked_pointer)
                        report_mismatch("acked_pointer", 32'(i_reply.acked_pointer),
                                        32'(want.acked_pointer));
                    if (i_reply.app_pointer !== want.app_pointer)
                        report_mismatch("app_pointer", 32'(i_reply.app_pointer),
                                        32'(want.app_pointer));
                    if (i_reply.min_window_out !== want.min_window_out)
                        report_mismatch("min_window_out", 32'(i_reply.min_window_out),
                                        32'(want.min_window_out));
                    o_checked++;
                end
            end
            if (i_start && !i_busy) begin
                if (i_req.opcode == OP_READ)
                    pending_replies.push_back(predict_read(i_req));
                else
                    update_mirror(i_req);
            end
            o_waiting = pending_replies.size();
        end
    end

endmodule

### dv/tb.sv
// testbench top: request stimulus, reply checker hookup and verdict
`timescale 1ns / 100ps
module tb;
    import spt_pkg::*;

    localparam int unsigned SESSIONS       = 1024;
    localparam int          RANDOM_WORDS   = 700;
    // the watchdog limit sits well above the longest sender gap
    localparam int          WATCHDOG_LIMIT = 1000;

    logic   clk = 1'b0;
    logic   rst_n;
    logic   start;
    t_req   req;
    logic   busy;
    logic   valid;
    t_reply reply;

    int mismatches;
    int waiting;
    int checked;

    // sessions whose ack init has been taken; only these may be read
    bit session_ready [SESSIONS];
    int words_by_op [4];
    int burst_left = 30;
    int stall_count = 0;

    always #1 clk = ~clk;

    session_pointer_table DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_start (start),
        .i_req   (req),
        .o_busy  (busy),
        .o_valid (valid),
        .o_reply (reply)
    );

    spt_reply_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_req        (req),
        .i_busy       (busy),
        .i_valid      (valid),
        .i_reply      (reply),
        .o_mismatches (mismatches),
        .o_waiting    (waiting),
        .o_checked    (checked)
    );

    function automatic t_req make_word(input t_opcode op, input int sid,
                                       input logic [15:0] ptr, input logic [15:0] win);
        t_req w;
        w.opcode        = op;
        w.session_id    = SID_BITS'(sid);
        w.pointer_value = ptr;
        w.window_value  = win;
        return w;
    endfunction

    // pointer and window values lean on the wrap points
    function automatic logic [15:0] random_field();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hffff;
            2:       return 16'h0001;
            default: return 16'($urandom);
        endcase
    endfunction

    // most words land on a few sessions at both ends of the table so that
    // reads hit entries that were recently rewritten
    function automatic t_req random_word();
        t_req w;
        int   pick;
        if ($urandom_range(0, 9) < 7)
            w.session_id = $urandom_range(0, 1) ? SID_BITS'($urandom_range(0, 7))
                                                : SID_BITS'(SESSIONS - 1 - $urandom_range(0, 7));
        else
            w.session_id = SID_BITS'($urandom);
        w.pointer_value = random_field();
        w.window_value  = random_field();
        pick = $urandom_range(0, 99);
        if (pick < 15)
            w.opcode = OP_ACK_INIT;
        else if (pick < 40)
            w.opcode = OP_ACK_UPDATE;
        else if (pick < 60)
            w.opcode = OP_APP_WRITE;
        else
            w.opcode = OP_READ;
        // never read an entry that has not been initialized
        if (w.opcode == OP_READ && !session_ready[w.session_id])
            w.opcode = OP_ACK_INIT;
        return w;
    endfunction

    // present one request word, hold it until taken, then maybe pause the sender
    task automatic send_word(input t_req w);
        int gap;
        @(negedge clk);
        start <= 1'b1;
        req   <= w;
        do @(posedge clk); while (busy);
        words_by_op[w.opcode]++;
        if (w.opcode == OP_ACK_INIT)
            session_ready[w.session_id] = 1'b1;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 5);
            repeat (gap) begin
                @(negedge clk);
                start <= 1'b0;
                req   <= t_req'({$urandom, $urandom});
            end
            // now and then a long gapless stretch
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 24);
        end else begin
            burst_left--;
        end
    endtask

    // watchdog: cycles with no request taken and no reply seen
    always @(posedge clk) begin
        if (rst_n) begin
            if ((start && !busy) || valid) begin
                stall_count <= 0;
            end else if (stall_count + 1 >= WATCHDOG_LIMIT) begin
                $display("timeout after %0d idle cycles", WATCHDOG_LIMIT);
                $display("session_pointer_table: mismatch");
                $finish;
            end else begin
                stall_count <= stall_count + 1;
            end
        end
    end

    initial begin
        rst_n = 1'b0;
        start = 1'b0;
        req   = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: init at zero wraps the acked pointer to all ones
        send_word(make_word(OP_ACK_INIT, 0, 16'h0000, 16'h0000));
        send_word(make_word(OP_READ, 0, 16'h0000, 16'h0000));
        // top session, all-ones values
        send_word(make_word(OP_ACK_INIT, SESSIONS - 1, 16'hffff, 16'hffff));
        send_word(make_word(OP_READ, SESSIONS - 1, 16'hffff, 16'hffff));
        // init at one leaves acked at zero
        send_word(make_word(OP_ACK_INIT, 1, 16'h0001, 16'h8000));
        send_word(make_word(OP_READ, 1, 16'h0000, 16'h0000));
        // ack update then app write, each read back in the next cycle
        send_word(make_word(OP_ACK_UPDATE, 1, 16'hffff, 16'habcd));
        send_word(make_word(OP_READ, 1, 16'h1234, 16'h0000));
        send_word(make_word(OP_APP_WRITE, 1, 16'h0000, 16'hffff));
        send_word(make_word(OP_READ, 1, 16'h0000, 16'h0000));
        send_word(make_word(OP_APP_WRITE, SESSIONS - 1, 16'h8000, 16'h0000));
        send_word(make_word(OP_ACK_UPDATE, SESSIONS - 1, 16'h0000, 16'h0001));
        send_word(make_word(OP_READ, SESSIONS - 1, 16'h0000, 16'h0000));
        // writes to an entry before its init, then init overrides both pointers
        send_word(make_word(OP_ACK_UPDATE, 512, 16'h5555, 16'haaaa));
        send_word(make_word(OP_APP_WRITE, 512, 16'haaaa, 16'h5555));
        send_word(make_word(OP_ACK_INIT, 512, 16'h7fff, 16'h7fff));
        send_word(make_word(OP_READ, 512, 16'h0000, 16'h0000));
        // back-to-back reads of different entries
        send_word(make_word(OP_READ, 0, 16'h0000, 16'h0000));
        send_word(make_word(OP_READ, SESSIONS - 1, 16'h0000, 16'h0000));
        send_word(make_word(OP_READ, 1, 16'h0000, 16'h0000));

        for (int n = 0; n < RANDOM_WORDS; n++)
            send_word(random_word());

        @(negedge clk);
        start <= 1'b0;
        // drain outstanding replies, then let any stray reply word show
        while (waiting != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("sent %0d ack updates, %0d ack inits, %0d app writes, %0d reads",
                 words_by_op[OP_ACK_UPDATE], words_by_op[OP_ACK_INIT],
                 words_by_op[OP_APP_WRITE], words_by_op[OP_READ]);
        $display("checked %0d reply words, %0d field errors", checked, mismatches);
        if (mismatches == 0 && waiting == 0)
            $display("session_pointer_table: match");
        else
            $display("session_pointer_table: mismatch");
        $finish;
    end

endmodule

### session_pointer_table.f
design/spt_pkg.sv
design/spt_store.sv
design/session_pointer_table.sv
dv/spt_reply_checker.sv
dv/tb.sv
